// ===== hw/rtl/buc_pkg.sv =====
// Shared types and constants for the battery undervoltage cutoff block.
package buc_pkg;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_TICK     = 2'd1,
        OP_SAMPLE   = 2'd2,
        OP_RESERVED = 2'd3
    } buc_op_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DIV_NUM      = 3'd0;
    localparam logic [2:0] CFG_DIV_DEN      = 3'd1;
    localparam logic [2:0] CFG_SAMPLES      = 3'd2;
    localparam logic [2:0] CFG_INTERVAL     = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT      = 3'd4;
    localparam logic [2:0] CFG_LOW_THRESH   = 3'd5;
    localparam logic [2:0] CFG_RECOV_THRESH = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // Configuration reset values.
    localparam logic [19:0] DIV_NUM_RST      = 20'd391000;
    localparam logic [19:0] DIV_DEN_RST      = 20'd91000;
    localparam logic [7:0]  SAMPLES_RST      = 8'd8;
    localparam logic [15:0] INTERVAL_RST     = 16'd10;
    localparam logic [15:0] TIMEOUT_RST      = 16'd2000;
    localparam logic [15:0] LOW_THRESH_RST   = 16'd3300;
    localparam logic [15:0] RECOV_THRESH_RST = 16'd3600;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] adc_millivolts;
    } buc_in_t;

    typedef struct packed {
        logic        load_on;
        logic        low_battery;
        logic        decided;
        logic        measurement_valid;
        logic [15:0] battery_mv;
    } buc_out_t;

    // Request to the shared divider: quotient is saturated to 16 bits.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [19:0] divisor;
    } buc_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
    } buc_div_rsp_t;

endpackage

// ===== hw/rtl/buc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transfer.
interface buc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/battery_undervoltage_cutoff.sv =====
// Battery undervoltage cutoff: averaging sequencer around a shared divider.
// Start, tick and ignored items go to the finish state, which registers the result once the output is free.
// A sample that opens a slot adds a multiply and one division before it is accumulated;
// the sample that closes the window adds the average division.
// One item at a time: the next item is taken when the sequencer is back in idle.
// Reset restores register defaults, stops measuring and turns the load off.
module battery_undervoltage_cutoff
    import buc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    buc_stream_if.sink             item,
    buc_stream_if.source           result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_MUL       = 6'b000010,
        ST_DIV_START = 6'b000100,
        ST_DIV_WAIT  = 6'b001000,
        ST_ACC       = 6'b010000,
        ST_FINISH    = 6'b100000
    } state_t;

    // Configuration registers.
    logic [19:0] div_num_reg;
    logic [19:0] div_den_reg;
    logic [7:0]  samples_reg;
    logic [15:0] interval_reg;
    logic [15:0] timeout_reg;
    logic [15:0] low_thresh_reg;
    logic [15:0] recov_thresh_reg;

    state_t      state_reg, state_next;
    logic        measuring_reg, measuring_next;
    logic [23:0] sum_reg, sum_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] since_reg, since_next;
    logic        first_reg, first_next;
    logic        low_reg, low_next;
    logic        load_reg, load_next;
    logic [15:0] last_mv_reg, last_mv_next;
    logic        avg_valid_reg, avg_valid_next;
    logic        mode_avg_reg, mode_avg_next;
    logic        out_valid_reg, out_valid_next;

    logic [1:0]  op_reg, op_next;
    logic [11:0] adc_reg, adc_next;
    logic [31:0] dividend_reg, dividend_next;
    logic [15:0] avg_reg, avg_next;
    buc_out_t    out_reg, out_next;

    buc_div_req_t div_req;
    buc_div_rsp_t div_rsp;

    logic        accept;
    logic [23:0] sum_inc;
    logic [7:0]  count_inc;
    logic        timed_out;
    logic        low_upd;

    buc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item.ready     = (state_reg == ST_IDLE);
    assign accept         = item.valid && item.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    assign div_req.start    = (state_reg == ST_DIV_START);
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = mode_avg_reg ? {12'b0, count_reg} : div_den_reg;

    assign sum_inc   = sum_reg + {8'b0, div_rsp.quotient};
    assign count_inc = count_reg + 8'd1;
    assign timed_out = (op_reg != OP_RESERVED) && measuring_reg && !avg_valid_reg
                       && (elapsed_reg >= timeout_reg);

    // Hysteresis on the averaged voltage.
    always_comb
    begin
        low_upd = low_reg;
        if (avg_reg < low_thresh_reg)
            low_upd = 1'b1;
        else if (low_reg && avg_reg >= recov_thresh_reg)
            low_upd = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        measuring_next = measuring_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        elapsed_next   = elapsed_reg;
        since_next     = since_reg;
        first_next     = first_reg;
        low_next       = low_reg;
        load_next      = load_reg;
        last_mv_next   = last_mv_reg;
        avg_valid_next = avg_valid_reg;
        mode_avg_next  = mode_avg_reg;
        out_valid_next = out_valid_reg && !result.ready;
        op_next        = op_reg;
        adc_next       = adc_reg;
        dividend_next  = dividend_reg;
        avg_next       = avg_reg;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = item.payload.op;
                    adc_next       = item.payload.adc_millivolts;
                    avg_valid_next = 1'b0;
                    state_next     = ST_FINISH;
                    unique case (buc_op_t'(item.payload.op))
                        OP_START:
                        begin
                            measuring_next = 1'b1;
                            sum_next       = '0;
                            count_next     = '0;
                            elapsed_next   = '0;
                            since_next     = '0;
                            first_next     = 1'b1;
                        end
                        OP_TICK:
                        begin
                            if (measuring_reg)
                            begin
                                elapsed_next = (elapsed_reg == 16'hFFFF) ? elapsed_reg
                                                                         : elapsed_reg + 16'd1;
                                since_next   = (since_reg == 16'hFFFF) ? since_reg
                                                                       : since_reg + 16'd1;
                            end
                        end
                        OP_SAMPLE:
                        begin
                            if (measuring_reg && (first_reg || since_reg >= interval_reg))
                            begin
                                // A zero reading still uses up the slot.
                                first_next = 1'b0;
                                since_next = '0;
                                if (item.payload.adc_millivolts != 12'd0)
                                    state_next = ST_MUL;
                            end
                        end
                        OP_RESERVED:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                dividend_next = {20'b0, adc_reg} * {12'b0, div_num_reg};
                mode_avg_next = 1'b0;
                state_next    = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (mode_avg_reg)
                    begin
                        avg_next       = div_rsp.quotient;
                        avg_valid_next = 1'b1;
                        state_next     = ST_FINISH;
                    end
                    else
                        state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                sum_next   = sum_inc;
                count_next = count_inc;
                if (!(count_inc < samples_reg || count_inc == 8'd0))
                begin
                    dividend_next = {8'b0, sum_inc};
                    mode_avg_next = 1'b1;
                    state_next    = ST_DIV_START;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next.decided           = avg_valid_reg || timed_out;
                    out_next.measurement_valid = avg_valid_reg;
                    out_next.load_on           = load_reg;
                    out_next.low_battery       = low_reg;
                    out_next.battery_mv        = last_mv_reg;
                    if (avg_valid_reg)
                    begin
                        measuring_next       = 1'b0;
                        low_next             = low_upd;
                        load_next            = !low_upd;
                        last_mv_next         = avg_reg;
                        out_next.low_battery = low_upd;
                        out_next.load_on     = !low_upd;
                        out_next.battery_mv  = avg_reg;
                    end
                    else if (timed_out)
                    begin
                        measuring_next       = 1'b0;
                        low_next             = 1'b1;
                        load_next            = 1'b0;
                        last_mv_next         = '0;
                        out_next.low_battery = 1'b1;
                        out_next.load_on     = 1'b0;
                        out_next.battery_mv  = '0;
                    end
                    avg_valid_next = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            measuring_reg <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            since_reg     <= '0;
            first_reg     <= 1'b1;
            low_reg       <= 1'b0;
            load_reg      <= 1'b0;
            last_mv_reg   <= '0;
            avg_valid_reg <= 1'b0;
            mode_avg_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            measuring_reg <= measuring_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            since_reg     <= since_next;
            first_reg     <= first_next;
            low_reg       <= low_next;
            load_reg      <= load_next;
            last_mv_reg   <= last_mv_next;
            avg_valid_reg <= avg_valid_next;
            mode_avg_reg  <= mode_avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        adc_reg      <= adc_next;
        dividend_reg <= dividend_next;
        avg_reg      <= avg_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_num_reg      <= DIV_NUM_RST;
            div_den_reg      <= DIV_DEN_RST;
            samples_reg      <= SAMPLES_RST;
            interval_reg     <= INTERVAL_RST;
            timeout_reg      <= TIMEOUT_RST;
            low_thresh_reg   <= LOW_THRESH_RST;
            recov_thresh_reg <= RECOV_THRESH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DIV_NUM:      div_num_reg      <= cfg_wdata;
                CFG_DIV_DEN:      div_den_reg      <= cfg_wdata;
                CFG_SAMPLES:      samples_reg      <= cfg_wdata[7:0];
                CFG_INTERVAL:     interval_reg     <= cfg_wdata[15:0];
                CFG_TIMEOUT:      timeout_reg      <= cfg_wdata[15:0];
                CFG_LOW_THRESH:   low_thresh_reg   <= cfg_wdata[15:0];
                CFG_RECOV_THRESH: recov_thresh_reg <= cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // The sequencer only starts the divider when it is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

    // A decision always leaves the load switch opposite the low state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.decided) |->
            (result.payload.load_on != result.payload.low_battery))
    else $error("load switch disagrees with low state after a decision");

    // A timeout decision forces the low state and reports zero millivolts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.decided && !result.payload.measurement_valid) |->
            (result.payload.low_battery && result.payload.battery_mv == 16'd0))
    else $error("timeout decision with wrong status");

    // An averaged result is only flagged together with a decision.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload.measurement_valid) |-> result.payload.decided)
    else $error("valid measurement without a decision");

endmodule

// ===== hw/rtl/buc_div.sv =====
// Radix-2 restoring divider with a 16-bit saturating quotient.
module buc_div
    import buc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  buc_div_req_t req,
    output buc_div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        sat_reg, sat_next;
    logic [19:0] rem_reg, rem_next;
    logic [15:0] dlo_reg, dlo_next;
    logic [15:0] quot_reg, quot_next;
    logic [19:0] divisor_reg, divisor_next;

    logic [20:0] trial;
    logic        fits;

    assign trial = {rem_reg, dlo_reg[15]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        sat_next     = sat_reg;
        rem_next     = rem_reg;
        dlo_next     = dlo_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            // The quotient overflows 16 bits exactly when the upper half of the
            // dividend already reaches the divisor; a zero divisor lands here too.
            busy_next    = 1'b1;
            cnt_next     = '0;
            sat_next     = {4'b0, req.dividend[31:16]} >= req.divisor;
            rem_next     = {4'b0, req.dividend[31:16]};
            dlo_next     = req.dividend[15:0];
            quot_next    = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? 20'(trial - {1'b0, divisor_reg}) : trial[19:0];
            dlo_next  = {dlo_reg[14:0], 1'b0};
            quot_next = {quot_reg[14:0], fits};
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        sat_reg     <= sat_next;
        rem_reg     <= rem_next;
        dlo_reg     <= dlo_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = sat_reg ? 16'hFFFF : quot_reg;

endmodule
